// File: hdl/mcg_pkg.sv
// Shared constants, types and month tables for the month calendar grid.
`default_nettype none
package mcg_pkg;

  localparam int GRID_ROWS = 6;
  localparam int WEEK_DAYS = 7;
  localparam int ROW_W     = $clog2(GRID_ROWS);

  // Field widths of the request and cell beats.
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DAY_W   = 5;
  localparam int COL_W   = 3;
  localparam int ROWO_W  = 3;
  localparam int LEAD_W  = 3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

  // y/100 as (y*5243)>>19, exact for 14-bit y
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  // s/7 as (s*37450)>>18, exact for 10-bit s
  localparam int DIV7_MUL     = 37450;
  localparam int DIV7_SHIFT   = 18;

  localparam int Q100_W = 8;
  localparam int K_W    = 7;
  localparam int SUM_W  = 10;

  typedef struct packed {
    logic [LEAD_W-1:0] lead;
    logic [DAY_W-1:0]  ndays;
    logic              invalid;
  } mcg_desc_t;

  // floor(13*(m+1)/5), m being the shifted month (Jan=13, Feb=14)
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] month);
    logic [5:0] t;
    case (month)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
    logic [DAY_W-1:0] d;
    case (month)
      4'd2:                 d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:              d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mcg_date_front.sv
// Request pipeline: range check, Zeller weekday of the 1st and month length.
`default_nettype none
module mcg_date_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire logic [mcg_pkg::MONTH_W-1:0]   month_number,
  input  wire logic [mcg_pkg::YEAR_W-1:0]    year_number,
  output logic                               desc_valid,
  input  wire logic                          desc_ready,
  output mcg_pkg::mcg_desc_t                 desc
);
  import mcg_pkg::*;

  // stage 1: input register
  logic               s1_valid;
  logic [MONTH_W-1:0] s1_month;
  logic [YEAR_W-1:0]  s1_year;
  // stage 2: year split into century and year-of-century
  logic               s2_valid;
  logic [MONTH_W-1:0] s2_month;
  logic [Q100_W-1:0]  s2_q;
  logic [K_W-1:0]     s2_k;
  logic               s2_leap;
  logic               s2_invalid;
  // stage 3: congruence sum
  logic               s3_valid;
  logic [SUM_W-1:0]   s3_sum;
  logic [DAY_W-1:0]   s3_ndays;
  logic               s3_invalid;

  logic en1, en2, en3, en4;

  assign en4 = !desc_valid || desc_ready;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign req_ready = en1;

  // stage 2 logic
  logic [YEAR_W+12:0]  prod100;
  logic [Q100_W-1:0]   q0;
  logic [Q100_W+6:0]   hundreds;
  logic [YEAR_W-1:0]   rem100;
  logic [K_W-1:0]      k0;
  logic                bad;

  assign prod100  = (YEAR_W+13)'(s1_year) * (YEAR_W+13)'(DIV100_MUL);
  assign q0       = prod100[DIV100_SHIFT +: Q100_W];
  assign hundreds = (Q100_W+7)'(q0) * (Q100_W+7)'(100);
  assign rem100   = s1_year - hundreds[YEAR_W-1:0];
  assign k0       = rem100[K_W-1:0];
  assign bad      = (s1_month == '0) || (s1_month > MONTH_DEC) ||
                    (s1_year == '0) || (s1_year > YEAR_MAX);

  // stage 3 logic: Jan/Feb belong to the previous year
  logic             jan_feb;
  logic [K_W-1:0]   k_adj;
  logic [Q100_W-1:0] q_adj;
  logic [K_W-1:0]   j;
  logic [SUM_W-1:0] sum;

  assign jan_feb = (s2_month == MONTH_JAN) || (s2_month == MONTH_FEB);

  always_comb begin
    k_adj = s2_k;
    q_adj = s2_q;
    if (jan_feb) begin
      if (s2_k == '0) begin
        k_adj = K_W'(99);
        q_adj = s2_q - 1'b1;
      end else begin
        k_adj = s2_k - 1'b1;
      end
    end
  end

  assign j = q_adj[K_W-1:0];
  // -2J folded to +5J modulo 7
  assign sum = SUM_W'(1) + SUM_W'(month_term(s2_month)) + SUM_W'(k_adj) +
               SUM_W'(k_adj >> 2) + SUM_W'(j >> 2) +
               SUM_W'({j, 2'b00}) + SUM_W'(j);

  // stage 4 logic: sum mod 7, then Zeller (0=Sat) to Sunday-first lead blanks
  logic [SUM_W+15:0] prod7;
  logic [6:0]        q7;
  logic [SUM_W-1:0]  rem7;
  logic [LEAD_W-1:0] zday;
  logic [LEAD_W-1:0] lead;

  assign prod7 = (SUM_W+16)'(s3_sum) * (SUM_W+16)'(DIV7_MUL);
  assign q7    = prod7[DIV7_SHIFT +: 7];
  assign rem7  = s3_sum - SUM_W'({q7, 3'b000} - {1'b0, q7});
  assign zday  = rem7[LEAD_W-1:0];
  assign lead  = (zday == '0) ? LEAD_W'(6) : zday - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      desc_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= req_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) desc_valid <= s3_valid;
    end
    if (en1) begin
      s1_month <= month_number;
      s1_year  <= year_number;
    end
    if (en2) begin
      s2_month   <= s1_month;
      s2_q       <= q0;
      s2_k       <= k0;
      s2_leap    <= (s1_year[1:0] == 2'b00) && ((k0 != '0) || (q0[1:0] == 2'b00));
      s2_invalid <= bad;
    end
    if (en3) begin
      s3_sum     <= sum;
      s3_ndays   <= month_days(s2_month, s2_leap);
      s3_invalid <= s2_invalid;
    end
    if (en4) begin
      desc.lead    <= lead;
      desc.ndays   <= s3_ndays;
      desc.invalid <= s3_invalid;
    end
  end

  a_lead_range: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> desc.lead <= LEAD_W'(6))
    else $error("lead blank count above six");

  a_ndays_range: assert property (@(posedge clk) disable iff (rst)
    desc_valid && !desc.invalid |-> desc.ndays >= DAY_W'(28))
    else $error("month length below 28");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    desc_valid && !desc_ready |=> desc_valid && $stable(desc))
    else $error("descriptor changed while stalled");

endmodule
`default_nettype wire

// File: hdl/mcg_cell_seq.sv
// Cell sequencer: walks the grid one cell per beat into the output register.
`default_nettype none
module mcg_cell_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        desc_valid,
  output logic                             desc_ready,
  input  wire mcg_pkg::mcg_desc_t          desc,
  output logic                             cell_valid,
  input  wire logic                        cell_ready,
  output logic [mcg_pkg::DAY_W-1:0]        day_of_month,
  output logic [mcg_pkg::COL_W-1:0]        weekday_column,
  output logic [mcg_pkg::ROWO_W-1:0]       grid_row,
  output logic                             last_cell,
  output logic                             invalid_request
);
  import mcg_pkg::*;

  logic              busy;
  mcg_desc_t         cur;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [DAY_W:0]    date;

  logic out_free, adv, finish, take, in_month;
  logic [ROWO_W:0]   row_ext;

  assign out_free   = !cell_valid || cell_ready;
  assign adv        = busy && out_free;
  assign finish     = cur.invalid ||
                      ((row == ROW_W'(GRID_ROWS-1)) && (col == COL_W'(WEEK_DAYS-1)));
  assign desc_ready = !busy || (adv && finish);
  assign take       = desc_valid && desc_ready;
  assign in_month   = ((row != '0) || (col >= cur.lead)) &&
                      (date <= (DAY_W+1)'(cur.ndays));
  assign row_ext    = (ROWO_W+1)'(row);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cell_valid <= 1'b0;
    end else begin
      if (out_free) cell_valid <= busy;
      if (take) busy <= 1'b1;
      else if (adv && finish) busy <= 1'b0;
    end
    if (adv) begin
      day_of_month    <= (in_month && !cur.invalid) ? date[DAY_W-1:0] : '0;
      weekday_column  <= cur.invalid ? '0 : col;
      grid_row        <= cur.invalid ? '0 : row_ext[ROWO_W-1:0];
      last_cell       <= finish;
      invalid_request <= cur.invalid;
    end
    if (take) begin
      cur  <= desc;
      row  <= '0;
      col  <= '0;
      date <= (DAY_W+1)'(1);
    end else if (adv) begin
      if (in_month) date <= date + 1'b1;
      if (col == COL_W'(WEEK_DAYS-1)) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  a_invalid_single: assert property (@(posedge clk) disable iff (rst)
    cell_valid && invalid_request |-> last_cell && (day_of_month == '0))
    else $error("invalid beat not a single blank final cell");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> weekday_column <= COL_W'(WEEK_DAYS-1))
    else $error("column out of range");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    cell_valid && last_cell && !invalid_request |->
      weekday_column == COL_W'(WEEK_DAYS-1))
    else $error("final cell not in the Saturday column");

endmodule
`default_nettype wire

// File: hdl/month_calendar_grid_core.sv
// Month calendar grid: one request beat (month, year) yields a month grid of cell beats.
//
// Request channel: req_valid/req_ready with month_number and year_number.
// Cell channel: cell_valid/cell_ready with day_of_month, weekday_column,
// grid_row, last_cell and invalid_request, one beat per grid cell in
// row-major order, Sunday first; blank cells carry day 0.
// A valid request gives GRID_ROWS*7 = 42 cell beats, last_cell on the final
// one. A month outside 1..12 or a year outside 1..9999 gives one beat with
// invalid_request and last_cell set.
// The first cell follows the request through the input register, three
// pipeline registers for the weekday and month length, the sequencer's
// descriptor register, then the cell register.
// The cell sequencer emits one cell per cycle on the result port while
// cell_ready is high, and takes the next descriptor as it emits the final cell.
// Up to four further requests queue in the front pipeline while a grid is
// being emitted. When the receiver stalls, the cell register holds and the
// pipeline fills, then req_ready drops. Synchronous reset empties all stages.
`default_nettype none
module month_calendar_grid_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [mcg_pkg::MONTH_W-1:0] month_number,
  input  wire logic [mcg_pkg::YEAR_W-1:0]  year_number,
  output logic                             cell_valid,
  input  wire logic                        cell_ready,
  output logic [mcg_pkg::DAY_W-1:0]        day_of_month,
  output logic [mcg_pkg::COL_W-1:0]        weekday_column,
  output logic [mcg_pkg::ROWO_W-1:0]       grid_row,
  output logic                             last_cell,
  output logic                             invalid_request
);
  import mcg_pkg::*;

  logic      desc_valid;
  logic      desc_ready;
  mcg_desc_t desc;

  mcg_date_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .month_number (month_number),
    .year_number  (year_number),
    .desc_valid   (desc_valid),
    .desc_ready   (desc_ready),
    .desc         (desc)
  );

  mcg_cell_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .desc_valid      (desc_valid),
    .desc_ready      (desc_ready),
    .desc            (desc),
    .cell_valid      (cell_valid),
    .cell_ready      (cell_ready),
    .day_of_month    (day_of_month),
    .weekday_column  (weekday_column),
    .grid_row        (grid_row),
    .last_cell       (last_cell),
    .invalid_request (invalid_request)
  );

endmodule
`default_nettype wire
